### hdl/as2p_pkg.sv
// as2p_pkg: shared constants and types for the audio sample to pcm16 converter
// no dependencies
`default_nettype none
package as2p_pkg;
  localparam logic [2:0] FmtU8  = 3'd0;
  localparam logic [2:0] FmtS16 = 3'd1;
  localparam logic [2:0] FmtS32 = 3'd2;
  localparam logic [2:0] FmtF32 = 3'd3;
  localparam logic [2:0] FmtF64 = 3'd4;

  localparam logic [1:0] RegFormat = 2'd0;
  localparam logic [1:0] RegGain   = 2'd1;
  localparam logic [1:0] RegOffset = 2'd2;

  localparam logic [2:0]  FormatReset = FmtS16;
  localparam logic [15:0] GainReset   = 16'd32767;
  localparam logic [7:0]  OffsetReset = 8'd128;

  localparam logic [16:0] PosMax = 17'd32767;
  localparam logic [16:0] NegMax = 17'd32768;

  // stage 1 -> stage 2: operand ready for multiply
  typedef struct packed {
    logic        valid;
    logic        is_float;
    logic        neg;
    logic        zero;      // result magnitude forced to zero
    logic        sat;       // magnitude forced to saturate
    logic        force_clip;
    logic [52:0] mant;      // magnitude or float mantissa
    logic [11:0] shift;     // float right shift (s)
    logic [1:0]  divsel;    // integer divisor select
  } s1_t;
endpackage
`default_nettype wire

### hdl/audio_sample_to_pcm16.sv
// audio_sample_to_pcm16: top level, config registers and conversion pipeline
// depends on as2p_pkg
//
// A sample is taken when start_i is high (busy_o is always low) and the result
// appears on pcm_sample_o/clipped_o with done_o high for exactly one cycle,
// once it has passed through every stage. One sample can enter every cycle; samples are independent.
// Stages: decode, partial products of mantissa times gain, sum, shift or
// reciprocal multiply for the integer divide, then correct and saturate.
// Integer divide by 2^(n-1)-1 uses x/(2^k-1) = (x + x>>k + x>>2k ...) >> k style
// reciprocal with one correcting compare/subtract.
// The receiver cannot stall; results are not held.
// Reset returns the registers to format signed 16-bit, gain 32767, offset 128
// and empties the pipeline. Registers are written through the APB port; the user must write them only
// while no sample is in flight, as the block itself does not enforce it.
`default_nettype none
module audio_sample_to_pcm16 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [63:0] raw_sample_i,
  output logic             done_o,
  output logic [15:0]      pcm_sample_o,
  output logic             clipped_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [2:0]  fmt_q;
  logic [15:0] gain_q;
  logic [7:0]  off_q;

  assign pready = 1'b1;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= as2p_pkg::FormatReset;
      gain_q <= as2p_pkg::GainReset;
      off_q  <= as2p_pkg::OffsetReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        as2p_pkg::RegFormat: fmt_q  <= pwdata[2:0];
        as2p_pkg::RegGain:   gain_q <= pwdata[15:0];
        as2p_pkg::RegOffset: off_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      as2p_pkg::RegFormat: prdata = {29'd0, fmt_q};
      as2p_pkg::RegGain:   prdata = {16'd0, gain_q};
      as2p_pkg::RegOffset: prdata = {24'd0, off_q};
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------- stage 1: decode
  as2p_pkg::s1_t s1_d, s1_q;
  logic [10:0] ex;
  logic [51:0] fr;
  logic        emaxv;
  logic [12:0] s_tmp;
  logic [8:0]  v8;
  logic [31:0] v32;

  always_comb begin
    s1_d = '0;
    s1_d.valid = start_i;
    ex = '0; fr = '0; emaxv = 1'b0; s_tmp = '0; v8 = '0; v32 = '0;
    case (fmt_q)
      as2p_pkg::FmtU8: begin
        v8 = {1'b0, raw_sample_i[7:0]} - {1'b0, off_q};
        s1_d.neg  = v8[8];
        s1_d.mant = {44'd0, v8[8] ? (9'd0 - v8) : v8};
        s1_d.divsel = 2'd0;
      end
      as2p_pkg::FmtS16: begin
        s1_d.neg  = raw_sample_i[15];
        s1_d.mant = {37'd0, raw_sample_i[15] ? (16'd0 - raw_sample_i[15:0])
                                             : raw_sample_i[15:0]};
        if (raw_sample_i[15:0] == 16'h8000) s1_d.mant = 53'h8000;
        s1_d.divsel = 2'd1;
      end
      as2p_pkg::FmtS32: begin
        v32 = raw_sample_i[31] ? (32'd0 - raw_sample_i[31:0]) : raw_sample_i[31:0];
        s1_d.neg  = raw_sample_i[31];
        s1_d.mant = {21'd0, v32};
        if (raw_sample_i[31:0] == 32'h8000_0000) s1_d.mant = 53'h8000_0000;
        s1_d.divsel = 2'd2;
      end
      as2p_pkg::FmtF32, as2p_pkg::FmtF64: begin
        s1_d.is_float = 1'b1;
        if (fmt_q == as2p_pkg::FmtF32) begin
          s1_d.neg = raw_sample_i[31];
          ex = {3'd0, raw_sample_i[30:23]};
          fr = {29'd0, raw_sample_i[22:0]};
          emaxv = &raw_sample_i[30:23];
          // s = 127 + 23 - ex (ex=0 -> 149)
          s_tmp = (ex == 11'd0) ? 13'd149 : 13'd150 - {2'd0, ex};
          s1_d.mant = {29'd0, ex != 11'd0, raw_sample_i[22:0]};
        end else begin
          s1_d.neg = raw_sample_i[63];
          ex = raw_sample_i[62:52];
          fr = raw_sample_i[51:0];
          emaxv = &raw_sample_i[62:52];
          s_tmp = (ex == 11'd0) ? 13'd1074 : 13'd1075 - {2'd0, ex};
          s1_d.mant = {ex != 11'd0, raw_sample_i[51:0]};
        end
        s1_d.shift = s_tmp[11:0];
        if (emaxv) begin
          if (fr != 52'd0) begin
            s1_d.zero = 1'b1; s1_d.neg = 1'b0; s1_d.force_clip = 1'b1;
          end else begin
            s1_d.sat = 1'b1; s1_d.force_clip = 1'b1;
          end
        end else if (s1_d.mant == 53'd0 || gain_q == 16'd0) begin
          s1_d.zero = 1'b1;
        end else if (s_tmp[12]) begin
          s1_d.sat = 1'b1;
        end
      end
      default: begin
        s1_d.zero = 1'b1;
      end
    endcase
    if (!s1_d.is_float && gain_q == 16'd0) s1_d.zero = 1'b1;
  end

  // ---------------- stage 2: partial products (mant split in 27-bit and 26-bit halves)
  logic [15:0] g1_q;
  as2p_pkg::s1_t s2_q;
  logic [42:0] plo_q, phi_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= s1_d;
      s2_q <= s1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    g1_q  <= gain_q;
    plo_q <= {16'd0, s1_q.mant[26:0]} * {27'd0, g1_q};
    phi_q <= {17'd0, s1_q.mant[52:27]} * {27'd0, g1_q};
  end

  // ---------------- stage 3: sum to full product (< 2^69)
  as2p_pkg::s1_t s3_q;
  logic [68:0] prod_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_q <= '0;
    else         s3_q <= s2_q;
  end
  always_ff @(posedge clk_i) begin
    prod_q <= {phi_q[41:0], 27'd0} + {26'd0, plo_q};
  end

  // ---------------- stage 4: float shift, or integer quotient estimate
  // x/(2^k-1): q0 = (x + (x>>k) + (x>>2k) ...) >> k, then one correction
  logic [68:0] shv;
  logic [47:0] xi, est;
  logic [17:0] q4_d;
  logic        big4_d;
  logic [47:0] x4_q;
  logic [17:0] q4_q;
  logic        big4_q;
  as2p_pkg::s1_t s4_q;
  always_comb begin
    shv = (s3_q.shift >= 12'd69) ? 69'd0 : (prod_q >> s3_q.shift);
    xi  = prod_q[47:0];
    est = '0;
    case (s3_q.divsel)
      2'd0:    est = (xi + (xi >> 7) + (xi >> 14) + (xi >> 21) + (xi >> 28)) >> 7;
      2'd1:    est = (xi + (xi >> 15) + (xi >> 30)) >> 15;
      default: est = (xi + (xi >> 31)) >> 31;
    endcase
    if (s3_q.is_float) begin
      big4_d = shv[68:17] != 52'd0;
      q4_d   = {1'b0, shv[16:0]};
    end else begin
      big4_d = est[47:18] != 30'd0;
      q4_d   = est[17:0];
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_q <= '0;
    else         s4_q <= s3_q;
  end
  always_ff @(posedge clk_i) begin
    x4_q   <= xi;
    q4_q   <= q4_d;
    big4_q <= big4_d;
  end

  // ---------------- stage 5: correct, saturate, output register
  logic [47:0] rem, dv;
  logic [17:0] q5;
  logic        big5;
  logic [16:0] lim;
  logic        clip5;
  logic [16:0] mag5;
  always_comb begin
    case (s4_q.divsel)
      2'd0:    dv = 48'd127;
      2'd1:    dv = 48'd32767;
      default: dv = 48'd2147483647;
    endcase
    rem  = x4_q - ({30'd0, q4_q} * dv);
    q5   = q4_q;
    big5 = big4_q;
    if (!s4_q.is_float && !big4_q && rem >= dv) q5 = q4_q + 18'd1;
    lim   = s4_q.neg ? as2p_pkg::NegMax : as2p_pkg::PosMax;
    clip5 = s4_q.force_clip;
    mag5  = q5[16:0];
    if (s4_q.zero) begin
      mag5 = '0;
    end else if (s4_q.sat || big5 || q5[17] || q5[16:0] > lim) begin
      mag5 = lim; clip5 = 1'b1;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= s4_q.valid;
  end
  always_ff @(posedge clk_i) begin
    pcm_sample_o <= s4_q.neg ? (16'd0 - mag5[15:0]) : mag5[15:0];
    clipped_o    <= clip5;
  end
endmodule
`default_nettype wire

### dv/testbench.sv
// testbench: self-checking bench for audio_sample_to_pcm16, with its own conversion predictor
// depends on as2p_pkg and audio_sample_to_pcm16
`default_nettype none
module testbench;
  localparam int PipeLatency = 5;
  localparam int WatchdogLimit = 20000;
  // format codes with no conversion defined
  localparam logic [2:0] FmtUnusedLo = 3'd5;
  localparam logic [2:0] FmtUnusedHi = 3'd7;

  typedef struct packed {
    logic [15:0] pcm;
    logic        clip;
  } pcm_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [63:0] raw_sample_i;
  logic        done_o;
  logic [15:0] pcm_sample_o;
  logic        clipped_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  audio_sample_to_pcm16 dut (.*);

  // configuration copy used by the predictor
  logic [2:0]  fmt_q;
  logic [15:0] gain_q;
  logic [7:0]  offset_q;

  pcm_result_t pending_pcm[$];
  int          fail_count;
  int          sent_count;
  int          recv_count;
  int          clip_count;
  int          idle_cycles;
  int          send_idle_pct;
  logic [4:0]  fmt_seen;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic pcm_result_t saturate(input bit neg, input logic [63:0] q, input bit clip_in);
    pcm_result_t r;
    logic [63:0] m;
    r.clip = clip_in;
    m = q;
    if (neg) begin
      if (m > 64'd32768) begin
        m = 64'd32768;
        r.clip = 1'b1;
      end
      r.pcm = 16'(-m);
    end else begin
      if (m > 64'd32767) begin
        m = 64'd32767;
        r.clip = 1'b1;
      end
      r.pcm = m[15:0];
    end
    return r;
  endfunction

  function automatic pcm_result_t convert_float(input logic [63:0] bits, input int mbits,
                                                input int ebits, input logic [15:0] g);
    logic [63:0] emax;
    logic [63:0] ex;
    logic [63:0] fr;
    logic [63:0] m;
    logic [127:0] prod;
    logic [63:0] q;
    bit neg;
    int bias;
    int s;
    pcm_result_t r;
    emax = (64'd1 << ebits) - 1;
    ex = (bits >> mbits) & emax;
    fr = bits & ((64'd1 << mbits) - 1);
    neg = bits[mbits + ebits];
    bias = (1 << (ebits - 1)) - 1;
    if (ex == emax) begin
      if (fr != 0) begin
        r.pcm = '0;
        r.clip = 1'b1;
        return r;
      end
      return saturate(neg, '1, 1'b1);
    end
    if (ex == 0) begin
      m = fr;
      s = bias + mbits - 1;
    end else begin
      m = fr | (64'd1 << mbits);
      s = bias + mbits - int'(ex);
    end
    prod = 128'(m) * 128'(g);
    if (m == 0 || g == 0) q = '0;
    else if (s < 0) q = '1;
    else if (s >= 128) q = '0;
    else begin
      prod = prod >> s;
      q = (prod[127:64] != 0) ? '1 : prod[63:0];
    end
    return saturate(neg, q, 1'b0);
  endfunction

  function automatic pcm_result_t convert_int(input longint v, input longint div,
                                              input logic [15:0] g);
    logic [63:0] mag;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    return saturate(v < 0, (mag * 64'(g)) / 64'(div), 1'b0);
  endfunction

  function automatic pcm_result_t predict_pcm(input logic [63:0] raw);
    pcm_result_t r;
    case (fmt_q)
      as2p_pkg::FmtU8:
        r = convert_int(longint'(raw[7:0]) - longint'(offset_q), 127, gain_q);
      as2p_pkg::FmtS16:
        r = convert_int(longint'($signed(raw[15:0])), 32767, gain_q);
      as2p_pkg::FmtS32:
        r = convert_int(longint'($signed(raw[31:0])), 2147483647, gain_q);
      as2p_pkg::FmtF32: r = convert_float({32'd0, raw[31:0]}, 23, 8, gain_q);
      as2p_pkg::FmtF64: r = convert_float(raw, 52, 11, gain_q);
      default: begin
        r.pcm = '0;
        r.clip = 1'b0;
      end
    endcase
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    pcm_result_t exp_r;
    if (rst_ni && done_o) begin
      recv_count <= recv_count + 1;
      if (pending_pcm.size() == 0) begin
        $display("%0t: unexpected result pcm=%h clip=%b", $time, pcm_sample_o, clipped_o);
        fail_count <= fail_count + 1;
      end else begin
        exp_r = pending_pcm.pop_front();
        if (exp_r.clip) clip_count <= clip_count + 1;
        if (pcm_sample_o !== exp_r.pcm || clipped_o !== exp_r.clip) begin
          $display("%0t: mismatch expected pcm=%h clip=%b actual pcm=%h clip=%b",
                   $time, exp_r.pcm, exp_r.clip, pcm_sample_o, clipped_o);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      as2p_pkg::RegFormat: fmt_q = value[2:0];
      as2p_pkg::RegGain:   gain_q = value[15:0];
      as2p_pkg::RegOffset: offset_q = value[7:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [63:0] raw);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (busy_o);
    pending_pcm.push_back(predict_pcm(raw));
    fmt_seen[fmt_q < 5 ? fmt_q : 0] = 1'b1;
    sent_count++;
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  task automatic configure(input logic [2:0] fmt, input logic [15:0] g, input logic [7:0] off);
    drain_results();
    write_reg(as2p_pkg::RegFormat, {29'd0, fmt});
    write_reg(as2p_pkg::RegGain, {16'd0, g});
    write_reg(as2p_pkg::RegOffset, {24'd0, off});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random float: exponent all ones, zero, near the interesting range, or fully random
  function automatic logic [63:0] rand_float(input bit dbl);
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(5, 0))
      0: v = dbl ? {v[63], 11'h7ff, v[51:0]} : {v[63:32], v[31], 8'hff, v[22:0]};
      1: v = dbl ? {v[63], 11'd0, v[51:0]} : {v[63:32], v[31], 8'd0, v[22:0]};
      2, 3, 4:
        v = dbl ? {v[63], 11'(1023 - 20 + $urandom_range(24, 0)), v[51:0]}
                : {v[63:32], v[31], 8'(127 - 20 + $urandom_range(24, 0)), v[22:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_reset_defaults();
    send_sample(64'h0000_0000_0000_7fff);
    send_sample(64'hffff_ffff_ffff_8000);
    send_sample(64'h1234_5678_9abc_0001);
    drain_results();
  endtask

  task automatic test_integer_extremes();
    configure(as2p_pkg::FmtU8, 16'd65535, 8'd128);
    send_sample(64'h00);
    send_sample(64'hff);
    send_sample(64'hffff_ffff_ffff_ff80);
    configure(as2p_pkg::FmtU8, 16'd1, 8'd255);
    send_sample(64'h00);
    send_sample(64'h7f);
    configure(as2p_pkg::FmtS16, 16'd65535, 8'd0);
    send_sample(64'h8000);
    send_sample(64'h7fff);
    configure(as2p_pkg::FmtS32, 16'd65535, 8'd0);
    send_sample(64'h8000_0000);
    send_sample(64'hffff_ffff_7fff_ffff);
    send_sample(64'h0000_0000_ffff_ffff);
  endtask

  task automatic test_float_cases();
    configure(as2p_pkg::FmtF32, 16'd32767, 8'd0);
    send_sample(64'h7f80_0000);  // +inf
    send_sample(64'hff80_0000);  // -inf
    send_sample(64'h7fc0_0001);  // nan
    send_sample(64'h8000_0000);  // negative zero
    send_sample(64'h3f80_0000);  // 1.0
    send_sample(64'hbf80_0000);
    send_sample(64'h0000_0001);  // denormal
    configure(as2p_pkg::FmtF64, 16'd0, 8'd0);
    send_sample(64'h7ff0_0000_0000_0000);
    send_sample(64'hfff0_0000_0000_0000);
    send_sample(64'h3ff0_0000_0000_0000);
    configure(as2p_pkg::FmtF64, 16'd65535, 8'd0);
    send_sample(64'h3fe0_0000_0000_0000);
    send_sample(64'hc0e0_0000_0000_0000);
    send_sample(64'h7fef_ffff_ffff_ffff);
    configure(FmtUnusedLo, 16'd100, 8'd0);
    send_sample(64'hffff_ffff_ffff_ffff);
    configure(FmtUnusedHi, 16'd100, 8'd0);
    send_sample(64'h1);
  endtask

  task automatic test_random_phase(input int pct, input int count);
    logic [2:0] f;
    logic [15:0] g;
    send_idle_pct = pct;
    for (int p = 0; p < 4; p++) begin
      f = 3'($urandom_range(5, 0));
      if (f == FmtUnusedLo) f = 3'($urandom_range(7, 5));
      case ($urandom_range(3, 0))
        0: g = 16'd65535;
        1: g = 16'($urandom_range(2, 0));
        default: g = 16'($urandom());
      endcase
      configure(f, g, 8'($urandom()));
      for (int i = 0; i < count / 4; i++) begin
        if (f == as2p_pkg::FmtF32 || f == as2p_pkg::FmtF64)
          send_sample(rand_float(f == as2p_pkg::FmtF64));
        else send_sample(rand64());
      end
    end
    drain_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    raw_sample_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    sent_count = 0;
    recv_count = 0;
    clip_count = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    fmt_seen = '0;
    fmt_q = as2p_pkg::FormatReset;
    gain_q = as2p_pkg::GainReset;
    offset_q = as2p_pkg::OffsetReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_integer_extremes();
    test_float_cases();
    test_random_phase(0, 100);
    test_random_phase(81, 100);
    test_random_phase(36, 100);
    test_random_phase(0, 100);
    drain_results();

    $display("covered %0d samples, %0d results, %0d clipped, formats seen %b",
             sent_count, recv_count, clip_count, fmt_seen);
    if (fail_count == 0 && pending_pcm.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
